// ===== hdl/chme_pkg.sv =====
// Shared types, register/segment codes and MD5 tables for the CAN history MAC engine.
// Used by chme_ctl, chme_dp and can_history_mac_engine; no dependencies.
`default_nettype none

package chme_pkg;

   // message byte counter width (inner message is at most 114 bytes with the default parameters)
   localparam int MSG_CNT_W = 8;

   // register indexes
   localparam logic [1:0] CSR_CAN_ID   = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd2;

   // byte stream segments
   localparam logic [3:0] SEG_KEY  = 4'd0;
   localparam logic [3:0] SEG_CTR  = 4'd1;
   localparam logic [3:0] SEG_ID   = 4'd2;
   localparam logic [3:0] SEG_HIST = 4'd3;
   localparam logic [3:0] SEG_PAY  = 4'd4;
   localparam logic [3:0] SEG_DIG  = 4'd5;
   localparam logic [3:0] SEG_ONE  = 4'd6;
   localparam logic [3:0] SEG_ZERO = 4'd7;
   localparam logic [3:0] SEG_LEN  = 4'd8;

   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5c;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;

   typedef struct packed {
      logic        op;
      logic [63:0] payload;
      logic [3:0]  pay_len;
      logic [31:0] recv_tag;
   } req_word_type;

   typedef struct packed {
      logic [31:0] tag_out;
      logic        ok;
      logic [3:0]  total_len;
   } rsp_word_type;

   typedef struct packed {
      logic                 load_item;
      logic                 push_byte;
      logic                 round_en;
      logic                 add_en;
      logic                 init_outer;
      logic                 finish;
      logic                 phase;
      logic [3:0]           seg;
      logic [5:0]           idx;
      logic [2:0]           hent;
      logic [5:0]           blkpos;
      logic [MSG_CNT_W-1:0] msgcnt;
      logic [5:0]           rnd;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] hist_count;
      logic [3:0] hent_len;
      logic [3:0] item_len;
      logic       out_full;
   } dp_sts_type;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   // rotate amount by round group and round index mod 4
   function automatic logic [4:0] md5_s(input logic [1:0] grp, input logic [1:0] col);
      logic [4:0] s;
      unique case ({grp, col})
         4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/chme_ctl.sv =====
// Sequencer for the CAN history MAC engine: walks the HMAC byte stream,
// MD5 rounds and block adds. Depends on chme_pkg.
`default_nettype none

module chme_ctl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire chme_pkg::dp_sts_type sts,
   output chme_pkg::ctl_cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FILL = 3'd1;
   localparam logic [2:0] ST_RND  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic       final_ff, final_in;
   logic [3:0] seg_ff, seg_in;
   logic [5:0] idx_ff, idx_in;
   logic [2:0] hent_ff, hent_in;
   logic [5:0] blkpos_ff, blkpos_in;
   logic [chme_pkg::MSG_CNT_W-1:0] msgcnt_ff, msgcnt_in;
   logic [5:0] rnd_ff, rnd_in;
   logic       emit, in_msg;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      final_in  = final_ff;
      seg_in    = seg_ff;
      idx_in    = idx_ff;
      hent_in   = hent_ff;
      blkpos_in = blkpos_ff;
      msgcnt_in = msgcnt_ff;
      rnd_in    = rnd_ff;
      emit      = 1'b0;
      in_msg    = 1'b0;
      cmd        = '0;
      cmd.phase  = phase_ff;
      cmd.seg    = seg_ff;
      cmd.idx    = idx_ff;
      cmd.hent   = hent_ff;
      cmd.blkpos = blkpos_ff;
      cmd.msgcnt = msgcnt_ff;
      cmd.rnd    = rnd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in  = ST_FILL;
               phase_in  = 1'b0;
               final_in  = 1'b0;
               seg_in    = chme_pkg::SEG_KEY;
               idx_in    = '0;
               hent_in   = '0;
               blkpos_in = '0;
               msgcnt_in = '0;
            end
         end
         ST_FILL: begin
            unique case (seg_ff)
               chme_pkg::SEG_KEY: begin
                  emit = 1'b1; in_msg = 1'b1;
                  idx_in = idx_ff + 6'd1;
                  if (idx_ff == 6'd63) begin
                     seg_in = phase_ff ? chme_pkg::SEG_DIG : chme_pkg::SEG_CTR;
                     idx_in = '0;
                  end
               end
               chme_pkg::SEG_CTR: begin
                  emit = 1'b1; in_msg = 1'b1;
                  idx_in = idx_ff + 6'd1;
                  if (idx_ff == 6'd7) begin
                     seg_in = chme_pkg::SEG_ID;
                     idx_in = '0;
                  end
               end
               chme_pkg::SEG_ID: begin
                  emit = 1'b1; in_msg = 1'b1;
                  idx_in = idx_ff + 6'd1;
                  if (idx_ff == 6'd1) begin
                     seg_in  = chme_pkg::SEG_HIST;
                     idx_in  = '0;
                     hent_in = '0;
                  end
               end
               chme_pkg::SEG_HIST: begin
                  if (hent_ff >= sts.hist_count) begin
                     seg_in = chme_pkg::SEG_PAY;
                     idx_in = '0;
                  end else if (idx_ff >= {2'b00, sts.hent_len}) begin
                     hent_in = hent_ff + 3'd1;
                     idx_in  = '0;
                  end else begin
                     emit = 1'b1; in_msg = 1'b1;
                     idx_in = idx_ff + 6'd1;
                  end
               end
               chme_pkg::SEG_PAY: begin
                  if (idx_ff >= {2'b00, sts.item_len}) begin
                     seg_in = chme_pkg::SEG_ONE;
                     idx_in = '0;
                  end else begin
                     emit = 1'b1; in_msg = 1'b1;
                     idx_in = idx_ff + 6'd1;
                  end
               end
               chme_pkg::SEG_DIG: begin
                  emit = 1'b1; in_msg = 1'b1;
                  idx_in = idx_ff + 6'd1;
                  if (idx_ff == 6'd15) begin
                     seg_in = chme_pkg::SEG_ONE;
                     idx_in = '0;
                  end
               end
               chme_pkg::SEG_ONE: begin
                  emit   = 1'b1;
                  seg_in = chme_pkg::SEG_ZERO;
               end
               chme_pkg::SEG_ZERO: begin
                  if (blkpos_ff == 6'd56) begin
                     seg_in = chme_pkg::SEG_LEN;
                     idx_in = '0;
                  end else begin
                     emit = 1'b1;
                  end
               end
               chme_pkg::SEG_LEN: begin
                  emit   = 1'b1;
                  idx_in = idx_ff + 6'd1;
                  if (idx_ff == 6'd7) final_in = 1'b1;
               end
               default: seg_in = chme_pkg::SEG_KEY;
            endcase
            if (emit) begin
               cmd.push_byte = 1'b1;
               blkpos_in = blkpos_ff + 6'd1;
               if (in_msg) msgcnt_in = msgcnt_ff + {{(chme_pkg::MSG_CNT_W-1){1'b0}}, 1'b1};
               if (blkpos_ff == 6'd63) begin
                  state_in = ST_RND;
                  rnd_in   = '0;
               end
            end
         end
         ST_RND: begin
            cmd.round_en = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_en = 1'b1;
            if (final_ff && !phase_ff) begin
               cmd.init_outer = 1'b1;
               phase_in  = 1'b1;
               final_in  = 1'b0;
               seg_in    = chme_pkg::SEG_KEY;
               idx_in    = '0;
               msgcnt_in = '0;
               state_in  = ST_FILL;
            end else if (final_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_DONE: begin
            if (!sts.out_full) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= 1'b0;
         final_ff  <= 1'b0;
         seg_ff    <= chme_pkg::SEG_KEY;
         idx_ff    <= '0;
         hent_ff   <= '0;
         blkpos_ff <= '0;
         msgcnt_ff <= '0;
         rnd_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         final_ff  <= final_in;
         seg_ff    <= seg_in;
         idx_ff    <= idx_in;
         hent_ff   <= hent_in;
         blkpos_ff <= blkpos_in;
         msgcnt_ff <= msgcnt_in;
         rnd_ff    <= rnd_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/chme_dp.sv =====
// Datapath of the CAN history MAC engine: registers, history, byte source,
// MD5 block buffer and round unit, result register. Depends on chme_pkg.
`default_nettype none

module chme_dp #(
   parameter int HIST_DEPTH  = 4,
   parameter int MAX_PAYLOAD = 8,
   parameter int TAG_BYTES   = 4,
   parameter int KEY_BYTES   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [63:0]            csr_wdata,
   input  wire chme_pkg::req_word_type req_word,
   input  wire chme_pkg::ctl_cmd_type  cmd,
   output chme_pkg::dp_sts_type        sts,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output chme_pkg::rsp_word_type      rsp_word
);

   localparam int HIDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam logic [31:0] TAG_MASK =
      (TAG_BYTES >= 4) ? 32'hffffffff : 32'((64'd1 << (8 * TAG_BYTES)) - 64'd1);

   logic [15:0] can_id_ff;
   logic [63:0] key_low_ff, key_high_ff;
   logic [63:0] counter_ff;
   logic [2:0]  hcount_ff;
   logic [63:0] hist_data_ff [HIST_DEPTH];
   logic [3:0]  hist_len_ff  [HIST_DEPTH];

   logic        op_ff;
   logic [63:0] data_ff, data_in;
   logic [3:0]  len_ff, len_in;
   logic [31:0] rtag_ff;

   logic [15:0][31:0] blk_ff;
   logic [3:0][31:0]  h_ff, st_ff, sum;
   logic [127:0]      dig_ff;

   logic                   rsp_valid_ff;
   chme_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [7:0]   byte_val;
   logic [127:0] key_all;
   logic [2:0]   ctr_sel;
   logic [HIDX_W-1:0] hidx;

   logic [31:0] f, tsum, rot, bb, cc, dd;
   logic [3:0]  g;
   logic [4:0]  sh;
   logic [31:0] tag;
   logic        ok;

   assign key_all = {key_high_ff, key_low_ff};
   assign ctr_sel = 3'd7 - cmd.idx[2:0];
   assign hidx    = cmd.hent[HIDX_W-1:0];

   // byte source for the hash stream
   always_comb begin
      byte_val = 8'h00;
      unique case (cmd.seg)
         chme_pkg::SEG_KEY: begin
            if (cmd.idx < 6'(KEY_BYTES)) byte_val = key_all[{cmd.idx[3:0], 3'b000} +: 8];
            byte_val = byte_val ^ (cmd.phase ? chme_pkg::OPAD : chme_pkg::IPAD);
         end
         chme_pkg::SEG_CTR:  byte_val = counter_ff[{ctr_sel, 3'b000} +: 8];
         chme_pkg::SEG_ID:   byte_val = cmd.idx[0] ? can_id_ff[7:0] : can_id_ff[15:8];
         chme_pkg::SEG_HIST: byte_val = hist_data_ff[hidx][{cmd.idx[2:0], 3'b000} +: 8];
         chme_pkg::SEG_PAY:  byte_val = data_ff[{cmd.idx[2:0], 3'b000} +: 8];
         chme_pkg::SEG_DIG:  byte_val = dig_ff[{cmd.idx[3:0], 3'b000} +: 8];
         chme_pkg::SEG_ONE:  byte_val = 8'h80;
         chme_pkg::SEG_ZERO: byte_val = 8'h00;
         chme_pkg::SEG_LEN: begin
            if (cmd.idx == 6'd0)      byte_val = {cmd.msgcnt[4:0], 3'b000};
            else if (cmd.idx == 6'd1) byte_val = {5'b00000, cmd.msgcnt[7:5]};
         end
         default: byte_val = 8'h00;
      endcase
   end

   // item capture: saturate length, zero unused bytes
   always_comb begin
      len_in = (req_word.pay_len > 4'(MAX_PAYLOAD)) ? 4'(MAX_PAYLOAD)
                                                     : req_word.pay_len;
      for (int j = 0; j < 8; j++)
         data_in[8*j +: 8] = (4'(j) < len_in) ? req_word.payload[8*j +: 8] : 8'h00;
   end

   // one MD5 round
   always_comb begin
      bb = st_ff[1];
      cc = st_ff[2];
      dd = st_ff[3];
      unique case (cmd.rnd[5:4])
         2'd0: begin f = (bb & cc) | (~bb & dd); g = cmd.rnd[3:0]; end
         2'd1: begin f = (dd & bb) | (~dd & cc); g = cmd.rnd[3:0] * 4'd5 + 4'd1; end
         2'd2: begin f = bb ^ cc ^ dd;           g = cmd.rnd[3:0] * 4'd3 + 4'd5; end
         2'd3: begin f = cc ^ (bb | ~dd);        g = cmd.rnd[3:0] * 4'd7; end
      endcase
      tsum = st_ff[0] + f + chme_pkg::md5_k(cmd.rnd) + blk_ff[g];
      sh   = chme_pkg::md5_s(cmd.rnd[5:4], cmd.rnd[1:0]);
      rot  = 32'({tsum, tsum} >> (6'd32 - {1'b0, sh}));
      for (int k = 0; k < 4; k++) sum[k] = h_ff[k] + st_ff[k];
   end

   // result
   always_comb begin
      tag = h_ff[0] & TAG_MASK;
      ok  = !op_ff || ((rtag_ff & TAG_MASK) == tag);
      rsp_in.tag_out   = tag;
      rsp_in.ok        = ok;
      rsp_in.total_len = len_ff + 4'(TAG_BYTES);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         can_id_ff    <= '0;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         counter_ff   <= '0;
         hcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               chme_pkg::CSR_CAN_ID:   can_id_ff   <= csr_wdata[15:0];
               chme_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
               chme_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            if (ok) begin
               counter_ff <= counter_ff + 64'd1;
               if (hcount_ff < 3'(HIST_DEPTH)) hcount_ff <= hcount_ff + 3'd1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // history and payload registers
   always_ff @(posedge clock) begin
      if (cmd.finish && ok) begin
         if (hcount_ff >= 3'(HIST_DEPTH)) begin
            for (int k = 0; k < HIST_DEPTH - 1; k++) begin
               hist_data_ff[k] <= hist_data_ff[k+1];
               hist_len_ff[k]  <= hist_len_ff[k+1];
            end
            hist_data_ff[HIST_DEPTH-1] <= data_ff;
            hist_len_ff[HIST_DEPTH-1]  <= len_ff;
         end else begin
            hist_data_ff[hcount_ff[HIDX_W-1:0]] <= data_ff;
            hist_len_ff[hcount_ff[HIDX_W-1:0]]  <= len_ff;
         end
      end
      if (cmd.finish) rsp_ff <= rsp_in;
      if (cmd.load_item) begin
         op_ff   <= req_word.op;
         data_ff <= data_in;
         len_ff  <= len_in;
         rtag_ff <= req_word.recv_tag;
         h_ff    <= {chme_pkg::IV3, chme_pkg::IV2, chme_pkg::IV1, chme_pkg::IV0};
         st_ff   <= {chme_pkg::IV3, chme_pkg::IV2, chme_pkg::IV1, chme_pkg::IV0};
      end else if (cmd.round_en) begin
         st_ff[0] <= dd;
         st_ff[1] <= bb + rot;
         st_ff[2] <= bb;
         st_ff[3] <= cc;
      end else if (cmd.add_en) begin
         if (cmd.init_outer) begin
            dig_ff <= sum;
            h_ff   <= {chme_pkg::IV3, chme_pkg::IV2, chme_pkg::IV1, chme_pkg::IV0};
            st_ff  <= {chme_pkg::IV3, chme_pkg::IV2, chme_pkg::IV1, chme_pkg::IV0};
         end else begin
            h_ff  <= sum;
            st_ff <= sum;
         end
      end
      if (cmd.push_byte) blk_ff[cmd.blkpos[5:2]][{cmd.blkpos[1:0], 3'b000} +: 8] <= byte_val;
   end

   assign sts.hist_count = hcount_ff;
   assign sts.hent_len   = hist_len_ff[hidx];
   assign sts.item_len   = len_ff;
   assign sts.out_full   = rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word       = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/can_history_mac_engine.sv =====
// CAN history MAC engine, top level: sequencer plus datapath.
// Depends on chme_pkg, chme_ctl and chme_dp.
`default_nettype none

// Signs or verifies one CAN payload per word with HMAC-MD5 under a 128-bit
// key written through the csr_ port (index 0 CAN id, 1 key bytes 0-7,
// 2 key bytes 8-15). The MAC covers the 64-bit message counter and the CAN
// id (both big-endian), the stored history payloads oldest first and the
// current payload; the tag is the first TAG_BYTES digest bytes. A sign or
// a matching verify pushes the payload into the history (oldest dropped
// when full) and bumps the counter; a failed verify leaves state untouched.
// One word is processed at a time. Each MD5 block loads the block buffer
// one byte a cycle, then runs 64 rounds on the single round unit and one
// add; at the default depth a word always needs four blocks, two inner
// and two outer (a third inner block once key pad plus message exceeds
// 119 bytes, which takes a deeper history). Byte loading pauses at each
// stored history entry and at segment changes. The result register lets
// a new request start while the previous result waits on rsp_stall; a
// waiting result only blocks completion of the next one.
// Reset: counter zero, history empty, registers zero.

module can_history_mac_engine #(
   parameter int HIST_DEPTH  = 4,
   parameter int MAX_PAYLOAD = 8,
   parameter int TAG_BYTES   = 4,
   parameter int KEY_BYTES   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [63:0]            csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire chme_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output chme_pkg::rsp_word_type      rsp_word
);

   chme_pkg::ctl_cmd_type cmd;
   chme_pkg::dp_sts_type  sts;

   // sequencer: byte stream, rounds, block adds, result handoff
   chme_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: registers, history, block buffer, round unit, result reg
   chme_dp #(
      .HIST_DEPTH  (HIST_DEPTH),
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .TAG_BYTES   (TAG_BYTES),
      .KEY_BYTES   (KEY_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // an accepted word keeps the engine busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine not busy after accept");

   // a result is never written over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.out_full)
      else $error("result register overwritten");

   // byte loading and rounds never overlap
   a_fill_vs_round: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push_byte && (cmd.round_en || cmd.add_en)))
      else $error("block buffer written during rounds");

   // history count stays within depth
   a_hist_bound: assert property (@(posedge clock) disable iff (reset)
      sts.hist_count <= 3'(HIST_DEPTH))
      else $error("history count out of range");

endmodule

`default_nettype wire

// ===== bench/can_history_mac_engine_tb.sv =====
// Testbench for can_history_mac_engine: sign/verify words checked against an
// in-bench HMAC-MD5 predictor with its own counter and payload history.
// Depends on chme_pkg and the can_history_mac_engine RTL.
`timescale 1ns / 1ps

module can_history_mac_engine_tb;

   localparam int HIST_DEPTH  = 4;
   localparam int MAX_PAYLOAD = 8;
   localparam int TAG_BYTES   = 4;
   localparam int KEY_BYTES   = 16;
   localparam int DRAIN_CYCLES = 700;     // idle margin after the queues empty
   localparam longint CYCLE_LIMIT = 8000000;

   localparam logic OP_SIGN   = 1'b0;
   localparam logic OP_VERIFY = 1'b1;

   // how the receive tag of a queued word is formed at launch time
   typedef enum logic [1:0] {TAG_AS_GIVEN, TAG_GOOD, TAG_FLIPPED} tag_mode_type;

   typedef struct {
      chme_pkg::req_word_type word;
      tag_mode_type tmode;
   } pending_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = chme_pkg::CSR_CAN_ID;
   logic [63:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   chme_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   chme_pkg::rsp_word_type rsp_word;

   can_history_mac_engine uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: configuration mirror plus counter and history
   // ---------------------------------------------------------------
   logic [15:0] pr_can_id;
   logic [63:0] pr_key_low, pr_key_high;
   logic [63:0] pr_counter;
   logic [63:0] pr_hist_data [HIST_DEPTH];
   logic [3:0]  pr_hist_len  [HIST_DEPTH];
   int          pr_hist_cnt;

   pending_word_type pending_words[$];
   chme_pkg::rsp_word_type expected_rsps[$];
   int  mismatch_count = 0;
   longint cycle_count = 0;
   bit  word_taken = 0;    // set at the edge that accepted the driven word

   const logic [31:0] round_k [64] = '{
      32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
      32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
      32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
      32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
      32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
      32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
      32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
      32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
      32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
      32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
      32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
   const int round_shift [16] = '{7,12,17,22, 5,9,14,20, 4,11,16,23, 6,10,15,21};

   // MD5 digest, digest byte i in bits 8i+7:8i
   function automatic logic [127:0] md5_digest(input logic [7:0] msg[$]);
      logic [7:0] padded[$];
      logic [63:0] bit_len;
      logic [31:0] h0, h1, h2, h3, a, b, c, d, f, t, x, m [16];
      int g;
      padded = msg;
      bit_len = 64'(msg.size()) * 8;
      padded.push_back(8'h80);
      while (padded.size() % 64 != 56) padded.push_back(8'h00);
      for (int i = 0; i < 8; i++) padded.push_back(bit_len[8*i +: 8]);
      h0 = 32'h67452301; h1 = 32'hefcdab89; h2 = 32'h98badcfe; h3 = 32'h10325476;
      for (int blk = 0; blk < padded.size(); blk += 64) begin
         for (int i = 0; i < 16; i++)
            m[i] = {padded[blk+4*i+3], padded[blk+4*i+2], padded[blk+4*i+1],
                    padded[blk+4*i]};
         a = h0; b = h1; c = h2; d = h3;
         for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
               f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
               f = (d & b) | (~d & c); g = (5*i + 1) % 16;
            end else if (i < 48) begin
               f = b ^ c ^ d; g = (3*i + 5) % 16;
            end else begin
               f = c ^ (b | ~d); g = (7*i) % 16;
            end
            x = a + f + round_k[i] + m[g];
            t = d; d = c; c = b;
            b = b + ((x << round_shift[(i/16)*4 + i%4]) |
                     (x >> (32 - round_shift[(i/16)*4 + i%4])));
            a = t;
         end
         h0 += a; h1 += b; h2 += c; h3 += d;
      end
      return {h3, h2, h1, h0};
   endfunction

   function automatic int clamp_len(input logic [3:0] l);
      return (l > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(l);
   endfunction

   function automatic logic [63:0] trim_payload(input logic [63:0] p, input int l);
      return (l >= 8) ? p : (p & ((64'd1 << (8*l)) - 1));
   endfunction

   // Tag over counter, CAN id, history and the current payload
   function automatic logic [31:0] frame_tag(input chme_pkg::req_word_type w);
      logic [7:0] key_pad [64];
      logic [7:0] inner_msg[$], outer_msg[$];
      logic [127:0] inner_dig, outer_dig;
      logic [31:0] tag;
      logic [63:0] data;
      int l;
      l = clamp_len(w.pay_len);
      data = trim_payload(w.payload, l);
      for (int i = 0; i < 64; i++) key_pad[i] = 8'h00;
      for (int i = 0; i < KEY_BYTES; i++)
         key_pad[i] = (i < 8) ? pr_key_low[8*i +: 8] : pr_key_high[8*(i-8) +: 8];
      for (int i = 0; i < 64; i++) inner_msg.push_back(key_pad[i] ^ 8'h36);
      for (int i = 7; i >= 0; i--) inner_msg.push_back(pr_counter[8*i +: 8]);
      inner_msg.push_back(pr_can_id[15:8]);
      inner_msg.push_back(pr_can_id[7:0]);
      for (int e = 0; e < pr_hist_cnt; e++)
         for (int j = 0; j < pr_hist_len[e]; j++)
            inner_msg.push_back(pr_hist_data[e][8*j +: 8]);
      for (int j = 0; j < l; j++) inner_msg.push_back(data[8*j +: 8]);
      inner_dig = md5_digest(inner_msg);
      for (int i = 0; i < 64; i++) outer_msg.push_back(key_pad[i] ^ 8'h5c);
      for (int i = 0; i < 16; i++) outer_msg.push_back(inner_dig[8*i +: 8]);
      outer_dig = md5_digest(outer_msg);
      tag = '0;
      for (int i = 0; i < TAG_BYTES; i++) tag[8*i +: 8] = outer_dig[8*i +: 8];
      return tag;
   endfunction

   // Expected response for an accepted word; commits history on success
   function automatic chme_pkg::rsp_word_type sign_or_verify(input chme_pkg::req_word_type w);
      chme_pkg::rsp_word_type r;
      logic [31:0] tag_mask;
      int l;
      l = clamp_len(w.pay_len);
      tag_mask = (TAG_BYTES >= 4) ? 32'hffffffff : ((32'd1 << (8*TAG_BYTES)) - 1);
      r.tag_out = frame_tag(w);
      r.ok = (w.op == OP_SIGN) || ((w.recv_tag & tag_mask) == r.tag_out);
      r.total_len = 4'(l + TAG_BYTES);
      if (r.ok) begin
         if (pr_hist_cnt >= HIST_DEPTH) begin
            for (int i = 1; i < HIST_DEPTH; i++) begin
               pr_hist_data[i-1] = pr_hist_data[i];
               pr_hist_len[i-1] = pr_hist_len[i];
            end
            pr_hist_cnt = HIST_DEPTH - 1;
         end
         pr_hist_data[pr_hist_cnt] = trim_payload(w.payload, l);
         pr_hist_len[pr_hist_cnt] = 4'(l);
         pr_hist_cnt++;
         pr_counter++;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Monitor: accepted requests feed the predictor, responses are checked
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      chme_pkg::rsp_word_type exp_rsp;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      word_taken <= (!reset && req_valid && !req_stall);
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(sign_or_verify(req_word));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_word);
            mismatch_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_word.tag_out !== exp_rsp.tag_out) begin
               $display("%0t: tag_out expected %h actual %h", $time,
                        exp_rsp.tag_out, rsp_word.tag_out);
               mismatch_count++;
            end
            if (rsp_word.ok !== exp_rsp.ok) begin
               $display("%0t: ok expected %b actual %b", $time, exp_rsp.ok, rsp_word.ok);
               mismatch_count++;
            end
            if (rsp_word.total_len !== exp_rsp.total_len) begin
               $display("%0t: total_len expected %0d actual %0d", $time,
                        exp_rsp.total_len, rsp_word.total_len);
               mismatch_count++;
            end
         end
      end
   end

   // Mostly short gaps, a few long ones; back-to-back stretches keyed off the cycle count
   function automatic int pick_gap();
      if (cycle_count[15:14] == 2'd0) return 0;
      if ($urandom_range(0, 99) < 60) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   // ---------------------------------------------------------------
   // Driver: launches queued words at the falling edge
   // ---------------------------------------------------------------
   int req_gap = 0;
   always @(negedge clock) begin
      logic next_valid;
      chme_pkg::req_word_type next_word;
      pending_word_type pw;
      next_valid = req_valid;
      next_word = req_word;
      if (word_taken) begin
         next_valid = 1'b0;
         req_gap = pick_gap();
      end
      if (!next_valid) begin
         if (req_gap > 0) req_gap--;
         else if (pending_words.size() != 0 && !reset) begin
            pw = pending_words.pop_front();
            next_word = pw.word;
            // predictor state is current here: only one word is ever in flight
            // from the driver's side, and it is launched after the last acceptance
            if (pw.tmode == TAG_GOOD) next_word.recv_tag = frame_tag(pw.word);
            else if (pw.tmode == TAG_FLIPPED)
               next_word.recv_tag = frame_tag(pw.word) ^ (32'd1 << $urandom_range(0, 31));
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_word <= next_word;
   end

   // Response backpressure: mostly short holds, a few long ones, none while cycle_count[14:13] is 1
   int rsp_hold = 0;
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if (cycle_count[14:13] != 2'd1 && $urandom_range(0, 3) == 0) begin
         rsp_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                : $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         chme_pkg::CSR_CAN_ID:   pr_can_id = val[15:0];
         chme_pkg::CSR_KEY_LOW:  pr_key_low = val;
         chme_pkg::CSR_KEY_HIGH: pr_key_high = val;
         default: ;
      endcase
   endtask

   task automatic queue_word(input logic op, input logic [63:0] p, input logic [3:0] l,
                             input logic [31:0] rt, input tag_mode_type tm);
      pending_word_type pw;
      pw.word.op = op;
      pw.word.payload = p;
      pw.word.pay_len = l;
      pw.word.recv_tag = rt;
      pw.tmode = tm;
      pending_words.push_back(pw);
   endtask

   // Sender holds off until the block is idle: nothing queued, nothing owed
   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_words(input int n);
      logic [63:0] p;
      logic [3:0] l;
      int r;
      for (int i = 0; i < n; i++) begin
         p = {$urandom, $urandom};
         l = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
         r = $urandom_range(0, 99);
         if (r < 40) queue_word(OP_SIGN, p, l, $urandom, TAG_AS_GIVEN);
         else if (r < 75) queue_word(OP_VERIFY, p, l, 32'h0, TAG_GOOD);
         else if (r < 88) queue_word(OP_VERIFY, p, l, 32'h0, TAG_FLIPPED);
         else queue_word(OP_VERIFY, p, l, $urandom, TAG_AS_GIVEN);
      end
   endtask

   initial begin
      pr_can_id = '0; pr_key_low = '0; pr_key_high = '0;
      pr_counter = '0; pr_hist_cnt = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset key, then length extremes, history wrap, verify outcomes
      queue_word(OP_SIGN, 64'h0, 4'd0, 32'h0, TAG_AS_GIVEN);
      queue_word(OP_SIGN, 64'hffff_ffff_ffff_ffff, 4'd8, 32'hffff_ffff, TAG_AS_GIVEN);
      queue_word(OP_SIGN, 64'hffff_ffff_ffff_ffff, 4'd15, 32'h0, TAG_AS_GIVEN);
      queue_word(OP_SIGN, 64'hffff_ffff_ffff_ffff, 4'd3, 32'h0, TAG_AS_GIVEN);
      queue_word(OP_VERIFY, 64'h0123_4567_89ab_cdef, 4'd1, 32'h0, TAG_GOOD);
      queue_word(OP_VERIFY, 64'h0123_4567_89ab_cdef, 4'd9, 32'h0, TAG_FLIPPED);
      queue_word(OP_VERIFY, 64'h0, 4'd0, 32'hffff_ffff, TAG_AS_GIVEN);
      queue_word(OP_VERIFY, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0, TAG_GOOD);
      drain();

      csr_write(chme_pkg::CSR_CAN_ID, 64'hffff_ffff_ffff_ffff);
      csr_write(chme_pkg::CSR_KEY_LOW, 64'hffff_ffff_ffff_ffff);
      csr_write(chme_pkg::CSR_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
      queue_word(OP_SIGN, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0, TAG_AS_GIVEN);
      queue_word(OP_VERIFY, 64'hdead_beef_cafe_f00d, 4'd7, 32'h0, TAG_GOOD);
      queue_word(OP_VERIFY, 64'h55aa_55aa_55aa_55aa, 4'd12, 32'h0, TAG_FLIPPED);
      queue_word(OP_SIGN, 64'h0, 4'd0, 32'h0, TAG_AS_GIVEN);
      queue_word(OP_VERIFY, 64'h8000_0000_0000_0001, 4'd8, 32'h0, TAG_GOOD);
      queue_word(OP_SIGN, 64'h1, 4'd4, 32'h0, TAG_AS_GIVEN);
      random_words(280);
      drain();

      // several random settings, last one back to all-zero
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(chme_pkg::CSR_CAN_ID, {48'h0, 16'($urandom)});
         csr_write(chme_pkg::CSR_KEY_LOW, {$urandom, $urandom});
         csr_write(chme_pkg::CSR_KEY_HIGH, {$urandom, $urandom});
         random_words(280);
         drain();
      end
      csr_write(chme_pkg::CSR_CAN_ID, 64'h0);
      csr_write(chme_pkg::CSR_KEY_LOW, 64'h0);
      csr_write(chme_pkg::CSR_KEY_HIGH, 64'h0);
      random_words(15);
      drain();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
